// File: sv/csr_pkg.sv
// Shared types and constants for the circle span rasterizer.
// Used by circle_span_rasterizer_core, csr_result and csr_checker.
package csr_pkg;

    // Screen size defaults
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // Field widths
    localparam int COORD_W = 12;   // centre and offsets
    localparam int SUM_W   = 13;   // centre plus or minus offset
    localparam int DEC_W   = 16;   // decision variable
    localparam int RAD_W   = 11;
    localparam int COL_W   = 8;
    localparam int XO_W    = 10;   // output column
    localparam int YO_W    = 9;    // output row

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Input item
    typedef struct packed {
        logic                       action;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [RAD_W-1:0]           radius;
        logic [COL_W-1:0]           color;
        logic                       filled;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               visible;
        logic [XO_W-1:0]    span_x_start;
        logic [XO_W-1:0]    span_x_end;
        logic [YO_W-1:0]    row;
        logic [COL_W-1:0]   pen_color;
        logic               end_of_step;
        logic               figure_done;
    } t_out_item;

    // Snapshot of one step, handed to the result former
    typedef struct packed {
        logic signed [COORD_W-1:0]  off_x;
        logic signed [COORD_W-1:0]  off_y;
        logic signed [COORD_W-1:0]  cen_x;
        logic signed [COORD_W-1:0]  cen_y;
        logic [COL_W-1:0]           color;
        logic                       fill;
        logic                       done;   // final step of the circle
        logic                       idle;   // step with no circle in progress
    } t_job;

endpackage

// File: sv/circle_span_rasterizer_core.sv
// Bresenham circle rasterizer: one start or step item in, clipped pixels or spans out.
// Depends on csr_pkg and csr_result.
//
// A start item (action 0) loads centre, radius, color and mode and gives
// no result. A step item (action 1) advances the decision variable at once and then
// sends its results from a snapshot, one per cycle through the output register
// while the output is not stalled: 8 results for an outline step, 4 for a filled
// step, 1 for a step with no circle in progress. The result emitter is the limit:
// the next item is taken in the cycle the last result of the current step enters the
// output register, so steps run back to back while the output is not stalled.
module circle_span_rasterizer_core #(
    parameter int SCREEN_WIDTH  = csr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = csr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csr_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csr_pkg::t_out_item  o_out_item
);

    localparam int CW = csr_pkg::COORD_W;
    localparam int SW = csr_pkg::SUM_W;
    localparam int DW = csr_pkg::DEC_W;

    // Circle state
    logic signed [CW-1:0]       r_cen_x, r_cen_y, r_off_x, r_off_y;
    logic [DW-1:0]              r_dec;
    logic [csr_pkg::COL_W-1:0]  r_color;
    logic                       r_fill, r_active;

    // Emitter state
    csr_pkg::t_job              r_job;
    logic                       r_busy;
    logic [2:0]                 r_idx;
    logic                       r_out_valid;
    csr_pkg::t_out_item         r_out;

    logic signed [CW-1:0]       n_off_x, n_off_y;
    logic [DW-1:0]              n_dec;
    logic                       n_done;
    logic                       load, emit, last, accept, is_step;
    csr_pkg::t_out_item         res;

    // Handshake
    assign load       = !r_out_valid || i_out_ready;
    assign emit       = r_busy && load;
    assign last       = r_job.idle || (r_job.fill ? (r_idx == 3'd3) : (r_idx == 3'd7));
    assign o_in_ready = !r_busy || (emit && last);
    assign accept     = i_in_valid && o_in_ready;
    assign is_step    = (i_in_item.action == csr_pkg::ACT_STEP);

    // Decision update for one step
    always_comb begin
        logic signed [SW-1:0] x13, y13, ny13, diff;
        logic [DW-1:0]        x16, diff16;
        x13    = {r_off_x[CW-1], r_off_x};
        y13    = {r_off_y[CW-1], r_off_y};
        diff   = x13 - y13;
        x16    = {{(DW-CW){r_off_x[CW-1]}}, r_off_x};
        diff16 = {{(DW-SW){diff[SW-1]}}, diff};
        if (r_dec[DW-1]) begin
            n_dec = r_dec + (x16 << 2) + DW'(6);
            ny13  = y13;
        end else begin
            n_dec = r_dec + (diff16 << 2) + DW'(10);
            ny13  = y13 - SW'(1);
        end
        n_off_x = r_off_x + CW'(1);
        n_off_y = ny13[CW-1:0];
        n_done  = (x13 + SW'(1)) > ny13;
    end

    // Circle state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen_x  <= '0;
            r_cen_y  <= '0;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_dec    <= '0;
            r_color  <= '0;
            r_fill   <= 1'b0;
            r_active <= 1'b0;
        end else if (accept) begin
            if (!is_step) begin
                r_cen_x  <= i_in_item.center_x;
                r_cen_y  <= i_in_item.center_y;
                r_off_x  <= '0;
                r_off_y  <= {1'b0, i_in_item.radius};
                r_dec    <= DW'(3) - {4'b0, i_in_item.radius, 1'b0};
                r_color  <= i_in_item.color;
                r_fill   <= i_in_item.filled;
                r_active <= 1'b1;
            end else if (r_active) begin
                r_off_x  <= n_off_x;
                r_off_y  <= n_off_y;
                r_dec    <= n_dec;
                r_active <= !n_done;
            end
        end
    end

    // Step snapshot and result counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (accept && is_step) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_step) begin
            r_job.off_x <= r_off_x;
            r_job.off_y <= r_off_y;
            r_job.cen_x <= r_cen_x;
            r_job.cen_y <= r_cen_y;
            r_job.color <= r_color;
            r_job.fill  <= r_fill;
            r_job.done  <= n_done;
            r_job.idle  <= !r_active;
        end
    end

    csr_result #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_result (
        .i_job  (r_job),
        .i_idx  (r_idx),
        .i_last (last),
        .o_res  (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: sv/csr_result.sv
// Forms one clipped result (pixel or span) of a step from the job snapshot.
// Depends on csr_pkg for t_job and t_out_item.
module csr_result #(
    parameter int SCREEN_WIDTH  = csr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = csr_pkg::SCREEN_HEIGHT_DEF
) (
    input  csr_pkg::t_job       i_job,
    input  logic [2:0]          i_idx,
    input  logic                i_last,
    output csr_pkg::t_out_item  o_res
);

    localparam logic signed [csr_pkg::SUM_W-1:0] WS  = csr_pkg::SUM_W'(SCREEN_WIDTH);
    localparam logic signed [csr_pkg::SUM_W-1:0] HS  = csr_pkg::SUM_W'(SCREEN_HEIGHT);
    localparam logic signed [csr_pkg::SUM_W-1:0] WM1 = csr_pkg::SUM_W'(SCREEN_WIDTH - 1);

    logic signed [csr_pkg::SUM_W-1:0] ox, oy, cx, cy;
    logic signed [csr_pkg::SUM_W-1:0] cpx, cmx, cpy, cmy, rpy, rmy, rpx, rmx;
    logic signed [csr_pkg::SUM_W-1:0] px, py, sa, sb, lo, hi;
    logic pix_vis, row_ok, span_vis;

    // Candidate columns and rows
    assign ox  = {i_job.off_x[csr_pkg::COORD_W-1], i_job.off_x};
    assign oy  = {i_job.off_y[csr_pkg::COORD_W-1], i_job.off_y};
    assign cx  = {i_job.cen_x[csr_pkg::COORD_W-1], i_job.cen_x};
    assign cy  = {i_job.cen_y[csr_pkg::COORD_W-1], i_job.cen_y};
    assign cpx = cx + ox;
    assign cmx = cx - ox;
    assign cpy = cx + oy;
    assign cmy = cx - oy;
    assign rpy = cy + oy;
    assign rmy = cy - oy;
    assign rpx = cy + ox;
    assign rmx = cy - ox;

    // Octant pixel select
    always_comb begin
        case (i_idx)
            3'd0: begin px = cpx; py = rpy; end
            3'd1: begin px = cmx; py = rpy; end
            3'd2: begin px = cpx; py = rmy; end
            3'd3: begin px = cmx; py = rmy; end
            3'd4: begin px = cpy; py = rpx; end
            3'd5: begin px = cmy; py = rpx; end
            3'd6: begin px = cpy; py = rmx; end
            default: begin px = cmy; py = rmx; end
        endcase
    end

    // Span ends for indexes 0..3, chosen by their own select on the low index bits
    always_comb begin
        case (i_idx[1:0])
            2'd0: begin sa = cpx; sb = cmx; end
            2'd1: begin sa = cpx; sb = cmx; end
            2'd2: begin sa = cpy; sb = cmy; end
            default: begin sa = cpy; sb = cmy; end
        endcase
    end

    // Order span ends
    assign lo = (sb < sa) ? sb : sa;
    assign hi = (sb < sa) ? sa : sb;

    // Clipping
    always_comb begin
        logic signed [csr_pkg::SUM_W-1:0] srow;
        srow     = (i_idx[1:0] == 2'd0) ? rpy :
                   (i_idx[1:0] == 2'd1) ? rmy :
                   (i_idx[1:0] == 2'd2) ? rpx : rmx;
        pix_vis  = (px >= 0) && (px < WS) && (py >= 0) && (py < HS);
        row_ok   = (srow >= 0) && (srow < HS);
        span_vis = row_ok && !(hi < 0) && !(lo >= WS);

        o_res              = '0;
        o_res.pen_color    = i_job.color;
        o_res.end_of_step  = i_last;
        o_res.figure_done  = i_job.done | i_job.idle;
        if (i_job.idle) begin
            o_res.visible = 1'b0;
        end else if (i_job.fill) begin
            o_res.visible = span_vis;
            if (span_vis) begin
                o_res.span_x_start = (lo < 0) ? '0 : lo[csr_pkg::XO_W-1:0];
                o_res.span_x_end   = (hi >= WS) ? WM1[csr_pkg::XO_W-1:0]
                                                : hi[csr_pkg::XO_W-1:0];
                o_res.row          = srow[csr_pkg::YO_W-1:0];
            end
        end else begin
            o_res.visible = pix_vis;
            if (pix_vis) begin
                o_res.span_x_start = px[csr_pkg::XO_W-1:0];
                o_res.span_x_end   = px[csr_pkg::XO_W-1:0];
                o_res.row          = py[csr_pkg::YO_W-1:0];
            end
        end
    end

endmodule

// File: sv/csr_checker.sv
// Port-level checks for circle_span_rasterizer_core, attached by bind.
// Depends on csr_pkg for the item types.
module csr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  csr_pkg::t_in_item   i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  csr_pkg::t_out_item  o_out_item
);

    // A waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while waiting");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // Results of one step follow each other without gaps
    a_step_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.end_of_step |=> o_out_valid)
        else $error("gap inside a step's results");

    // Invisible items carry zero coordinates
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.visible |->
            o_out_item.span_x_start == '0 && o_out_item.span_x_end == '0 &&
            o_out_item.row == '0)
        else $error("invisible item with coordinates");

    // Visible spans are ordered
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.visible |->
            o_out_item.span_x_start <= o_out_item.span_x_end)
        else $error("span ends out of order");

endmodule

bind circle_span_rasterizer_core csr_checker u_csr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
